// ===== rtl/hlw_pkg.sv =====
// shared types, codes and rule helpers for the hex lattice worm step engine
package hlw_pkg;

    // default grid side of the square map
    localparam int GRID_SIDE_DEFAULT = 128;

    // result status codes
    typedef enum logic [2:0] {
        ST_MOVED       = 3'd0,
        ST_LEFT_GRID   = 3'd1,
        ST_NO_FREE     = 3'd2,
        ST_BAD_PATTERN = 3'd3,
        ST_STOPPED     = 3'd4,
        ST_READ        = 3'd5
    } hlw_status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ONE_EATEN  = 3'd0,
        CFG_TWO_EATEN  = 3'd1,
        CFG_THREE_A    = 3'd2,
        CFG_THREE_B    = 3'd3,
        CFG_THREE_C    = 3'd4,
        CFG_THREE_D    = 3'd5,
        CFG_FOUR_EATEN = 3'd6
    } hlw_cfg_t;

    // command codes
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // rule digits
    typedef struct packed {
        logic       one_eaten;
        logic [1:0] two_eaten;
        logic [1:0] three_a;
        logic [1:0] three_b;
        logic [1:0] three_c;
        logic [1:0] three_d;
        logic       four_eaten;
    } hlw_rules_t;

    // outcome of one edge scan
    typedef struct packed {
        logic       done;
        logic       bad;
        logic       found;
        logic [2:0] dir;
    } hlw_scan_res_t;

    // rule digit tables
    localparam logic [2:0] ONE_PASS  [2] = '{3'd3, 3'd4};
    localparam logic [1:0] FIRST_ALT [3] = '{2'd2, 2'd0, 2'd1};
    localparam logic [1:0] MID_ALT   [3] = '{2'd1, 2'd0, 2'd2};

    // direction plus offset, modulo six
    function automatic logic [2:0] dir_add(input logic [2:0] a, input logic [2:0] k);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, k};
        return (s >= 4'd6) ? 3'(s - 4'd6) : s[2:0];
    endfunction

    // one-hot edge mask for a direction
    function automatic logic [5:0] dir_bit(input logic [2:0] d);
        return 6'(1) << d;
    endfunction

    // digit for a node with three eaten segments saturates at two
    function automatic logic [1:0] sat2(input logic [1:0] v);
        return (v == 2'd3) ? 2'd2 : v;
    endfunction

    // free edges to pass plus one, zero flags an unlisted pattern
    function automatic logic [2:0] pass_count(input logic [5:0] bits, input logic [2:0] arr,
                                              input hlw_rules_t rules);
        logic [2:0] n;
        logic       e1, e2, e3, e4, e5;
        logic [1:0] da, db, dc, dd;
        n = 3'd0;
        for (int i = 0; i < 6; i++) begin
            n = n + 3'(bits[i]);
        end
        e1 = bits[dir_add(arr, 3'd1)];
        e2 = bits[dir_add(arr, 3'd2)];
        e3 = bits[dir_add(arr, 3'd3)];
        e4 = bits[dir_add(arr, 3'd4)];
        e5 = bits[dir_add(arr, 3'd5)];
        da = sat2(rules.three_a);
        db = sat2(rules.three_b);
        dc = sat2(rules.three_c);
        dd = sat2(rules.three_d);
        if (n == 3'd1) return ONE_PASS[rules.one_eaten] + 3'd1;
        if (n == 3'd2) return {1'b0, rules.two_eaten} + 3'd1;
        if (n == 3'd4) return {2'b00, rules.four_eaten} + 3'd1;
        if (n != 3'd3) return 3'd1;
        if (e1 && e2) return {1'b0, da} + 3'd1;
        if (e1 && e3) return {1'b0, FIRST_ALT[da]} + 3'd1;
        if (e3 && e2) return {1'b0, db} + 3'd1;
        if (e5 && e1) return {1'b0, MID_ALT[db]} + 3'd1;
        if (e4 && e3) return {1'b0, dc} + 3'd1;
        if (e4 && e2) return {1'b0, MID_ALT[dc]} + 3'd1;
        if (e5 && e4) return {1'b0, dd} + 3'd1;
        if (e5 && e3) return {1'b0, dd} + 3'd1;
        return 3'd0;
    endfunction

endpackage

// ===== rtl/hlw_scan.sv =====
// iterative edge scanner: passes one edge per cycle to find the chosen free edge
module hlw_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [5:0]            here,
    input  logic [2:0]            arr,
    input  hlw_pkg::hlw_rules_t   rules,
    output hlw_pkg::hlw_scan_res_t res
);
    import hlw_pkg::*;

    logic          run_reg, run_next;
    logic [2:0]    choice_reg, choice_next;
    logic [2:0]    count_reg, count_next;
    logic [5:0]    bits_reg, bits_next;
    logic [2:0]    arr_reg, arr_next;
    hlw_scan_res_t res_reg, res_next;

    logic [2:0]    cnt_inc;
    logic [2:0]    cur_dir;
    logic [2:0]    choice_dec;

    // one edge per cycle
    always_comb
    begin
        cnt_inc    = count_reg + 3'd1;
        cur_dir    = dir_add(arr_reg, cnt_inc);
        choice_dec = bits_reg[cur_dir] ? choice_reg : choice_reg - 3'd1;
    end

    always_comb
    begin
        run_next     = run_reg;
        choice_next  = choice_reg;
        count_next   = count_reg;
        bits_next    = bits_reg;
        arr_next     = arr_reg;
        res_next     = res_reg;
        res_next.done = 1'b0;
        if (go) begin
            run_next    = 1'b1;
            choice_next = pass_count(here, arr, rules);
            count_next  = 3'd0;
            bits_next   = here;
            arr_next    = arr;
        end else if (run_reg) begin
            if (choice_reg == 3'd0) begin
                // unlisted pattern of three eaten segments
                run_next = 1'b0;
                res_next = '{done: 1'b1, bad: 1'b1, found: 1'b0, dir: 3'd0};
            end else if (choice_dec == 3'd0) begin
                run_next = 1'b0;
                res_next = '{done: 1'b1, bad: 1'b0, found: 1'b1, dir: cur_dir};
            end else if (cnt_inc == 3'd5) begin
                // ran out of edges
                run_next = 1'b0;
                res_next = '{done: 1'b1, bad: 1'b0, found: 1'b0, dir: 3'd0};
            end else begin
                count_next  = cnt_inc;
                choice_next = choice_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg    <= 1'b0;
            res_reg    <= '0;
            choice_reg <= 3'd0;
            count_reg  <= 3'd0;
        end else begin
            run_reg    <= run_next;
            res_reg    <= res_next;
            choice_reg <= choice_next;
            count_reg  <= count_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        arr_reg  <= arr_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/hlw_map.sv =====
// single-port edge map memory with a clearing pass after reset
module hlw_map #(
    parameter int GRID_SIDE = hlw_pkg::GRID_SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic                                wr_en,
    input  logic [2*$clog2(GRID_SIDE)-1:0]      addr,
    input  logic [5:0]                          wdata,
    output logic [5:0]                          rdata,
    output logic                                clearing
);
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam logic [COORD_W-1:0] MID = COORD_W'(GRID_SIDE / 2);
    localparam logic [ADDR_W-1:0]  START_ADDR = {MID, MID};
    localparam logic [ADDR_W-1:0]  FIRST_ADDR = {MID + COORD_W'(1), MID};

    logic [5:0]        mem [DEPTH];
    logic [5:0]        rdata_reg;
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [5:0]        wd;
    logic [5:0]        init_val;

    // reset contents: first segment eaten at both ends
    always_comb
    begin
        if (clr_addr_reg == START_ADDR) begin
            init_val = 6'd1;
        end else if (clr_addr_reg == FIRST_ADDR) begin
            init_val = 6'd8;
        end else begin
            init_val = 6'd0;
        end
    end

    // write port select, clearing pass first
    always_comb
    begin
        we = clearing_reg ? 1'b1 : wr_en;
        wa = clearing_reg ? clr_addr_reg : addr;
        wd = clearing_reg ? init_val : wdata;
    end

    // clearing sequencer
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== rtl/hex_lattice_worm_step.sv =====
// top level: paterson's worm step engine with command sequencer and config registers
//
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. A read is
// accepted with a read of the map memory and finishes in S_LOAD, where the
// registered read data is taken and done is raised. A step reads the worm's node,
// loads the rule count, runs the edge scanner that passes one edge per cycle,
// then reads the target node and makes two writes on the single map port; a
// step that fails or is refused ends sooner. After reset the map is swept once,
// one entry per cycle, over all 4**ceil(log2(GRID_SIDE)) entries (16384 at the
// default side) while busy stays high; configuration writes are taken at any
// time and cfg_ready is always high.
module hex_lattice_worm_step #(
    parameter int GRID_SIDE = hlw_pkg::GRID_SIDE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       cmd,
    input  logic [6:0] read_x,
    input  logic [6:0] read_y,
    output logic       done,
    output logic [2:0] status,
    output logic [6:0] pos_x,
    output logic [6:0] pos_y,
    output logic [2:0] direction,
    output logic [5:0] node_edges,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [1:0] cfg_data
);
    import hlw_pkg::*;

    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int EXT_W   = ((COORD_W > 7) ? COORD_W : 7) + 1;
    localparam logic [COORD_W-1:0] MID   = COORD_W'(GRID_SIDE / 2);
    localparam logic [COORD_W-1:0] X_MAX = COORD_W'(GRID_SIDE - 1);
    localparam logic [EXT_W-1:0]   SIDE_EXT = EXT_W'(GRID_SIDE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_NEWRD,
        S_OLDWR
    } state_t;

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] worm_x_reg, worm_x_next;
    logic [COORD_W-1:0] worm_y_reg, worm_y_next;
    logic [2:0]         heading_reg, heading_next;
    logic               stopped_reg, stopped_next;
    logic               done_reg, done_next;
    hlw_status_t        status_reg, status_next;
    logic [5:0]         shown_reg, shown_next;
    logic               cmd_reg, cmd_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [5:0]         here_reg, here_next;
    logic [2:0]         nd_reg, nd_next;
    logic [COORD_W-1:0] new_x_reg, new_x_next;
    logic [COORD_W-1:0] new_y_reg, new_y_next;
    hlw_rules_t         rules_reg;

    logic               accept;
    logic               clearing;
    logic               mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]  mem_addr;
    logic [5:0]         mem_wdata, mem_rdata;
    logic               scan_go;
    hlw_scan_res_t      scan_res;
    logic [EXT_W-1:0]   rx_ext, ry_ext, px_ext, py_ext;
    logic               rd_in_grid;
    logic               x_inc, x_dec, y_inc, y_dec, off_grid;
    logic [COORD_W-1:0] nx, ny;

    // command port
    assign busy   = (state_reg != S_IDLE) || clearing;
    assign accept = start && !busy;

    // read coordinates against the grid
    always_comb
    begin
        rx_ext     = EXT_W'(read_x);
        ry_ext     = EXT_W'(read_y);
        rd_in_grid = (rx_ext < SIDE_EXT) && (ry_ext < SIDE_EXT);
    end

    // neighbor in the chosen direction and grid bounds
    always_comb
    begin
        x_inc    = (scan_res.dir == 3'd0) || (scan_res.dir == 3'd1);
        x_dec    = (scan_res.dir == 3'd3) || (scan_res.dir == 3'd4);
        y_dec    = (scan_res.dir == 3'd1) || (scan_res.dir == 3'd2);
        y_inc    = (scan_res.dir == 3'd4) || (scan_res.dir == 3'd5);
        off_grid = (x_inc && worm_x_reg == X_MAX) || (x_dec && worm_x_reg == '0)
                || (y_inc && worm_y_reg == X_MAX) || (y_dec && worm_y_reg == '0);
        nx = x_inc ? worm_x_reg + COORD_W'(1) : (x_dec ? worm_x_reg - COORD_W'(1) : worm_x_reg);
        ny = y_inc ? worm_y_reg + COORD_W'(1) : (y_dec ? worm_y_reg - COORD_W'(1) : worm_y_reg);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        worm_x_next  = worm_x_reg;
        worm_y_next  = worm_y_reg;
        heading_next = heading_reg;
        stopped_next = stopped_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        shown_next   = shown_reg;
        cmd_next     = cmd_reg;
        rd_ok_next   = rd_ok_reg;
        here_next    = here_reg;
        nd_next      = nd_reg;
        new_x_next   = new_x_reg;
        new_y_next   = new_y_reg;
        mem_rd_en    = 1'b0;
        mem_wr_en    = 1'b0;
        mem_addr     = {worm_x_reg, worm_y_reg};
        mem_wdata    = 6'd0;
        scan_go      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    mem_rd_en  = 1'b1;
                    cmd_next   = cmd;
                    rd_ok_next = rd_in_grid;
                    if (cmd == CMD_READ) begin
                        mem_addr = {rx_ext[COORD_W-1:0], ry_ext[COORD_W-1:0]};
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                here_next = mem_rdata;
                if (cmd_reg == CMD_READ) begin
                    done_next   = 1'b1;
                    status_next = ST_READ;
                    shown_next  = rd_ok_reg ? mem_rdata : 6'd0;
                    state_next  = S_IDLE;
                end else if (stopped_reg) begin
                    done_next   = 1'b1;
                    status_next = ST_STOPPED;
                    shown_next  = mem_rdata;
                    state_next  = S_IDLE;
                end else begin
                    scan_go    = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_res.done) begin
                    shown_next = here_reg;
                    if (scan_res.bad) begin
                        done_next    = 1'b1;
                        status_next  = ST_BAD_PATTERN;
                        stopped_next = 1'b1;
                        state_next   = S_IDLE;
                    end else if (!scan_res.found) begin
                        done_next    = 1'b1;
                        status_next  = ST_NO_FREE;
                        stopped_next = 1'b1;
                        state_next   = S_IDLE;
                    end else if (off_grid) begin
                        done_next    = 1'b1;
                        status_next  = ST_LEFT_GRID;
                        stopped_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        mem_rd_en  = 1'b1;
                        mem_addr   = {nx, ny};
                        nd_next    = scan_res.dir;
                        new_x_next = nx;
                        new_y_next = ny;
                        state_next = S_NEWRD;
                    end
                end
            end
            S_NEWRD:
            begin
                // mark the arrival edge at the target node
                mem_wr_en  = 1'b1;
                mem_addr   = {new_x_reg, new_y_reg};
                mem_wdata  = mem_rdata | dir_bit(dir_add(nd_reg, 3'd3));
                shown_next = mem_wdata;
                state_next = S_OLDWR;
            end
            S_OLDWR:
            begin
                // mark the departure edge at the old node and move
                mem_wr_en    = 1'b1;
                mem_addr     = {worm_x_reg, worm_y_reg};
                mem_wdata    = here_reg | dir_bit(nd_reg);
                worm_x_next  = new_x_reg;
                worm_y_next  = new_y_reg;
                heading_next = nd_reg;
                done_next    = 1'b1;
                status_next  = ST_MOVED;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            worm_x_reg  <= MID + COORD_W'(1);
            worm_y_reg  <= MID;
            heading_reg <= 3'd0;
            stopped_reg <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= ST_MOVED;
            cmd_reg     <= CMD_STEP;
        end else begin
            state_reg   <= state_next;
            worm_x_reg  <= worm_x_next;
            worm_y_reg  <= worm_y_next;
            heading_reg <= heading_next;
            stopped_reg <= stopped_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            cmd_reg     <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shown_reg <= shown_next;
        rd_ok_reg <= rd_ok_next;
        here_reg  <= here_next;
        nd_reg    <= nd_next;
        new_x_reg <= new_x_next;
        new_y_reg <= new_y_next;
    end

    // rule digit registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rules_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ONE_EATEN:  rules_reg.one_eaten  <= cfg_data[0];
                CFG_TWO_EATEN:  rules_reg.two_eaten  <= cfg_data;
                CFG_THREE_A:    rules_reg.three_a    <= cfg_data;
                CFG_THREE_B:    rules_reg.three_b    <= cfg_data;
                CFG_THREE_C:    rules_reg.three_c    <= cfg_data;
                CFG_THREE_D:    rules_reg.three_d    <= cfg_data;
                CFG_FOUR_EATEN: rules_reg.four_eaten <= cfg_data[0];
                default:        rules_reg            <= rules_reg;
            endcase
        end
    end

    hlw_map #(
        .GRID_SIDE (GRID_SIDE)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .wr_en    (mem_wr_en),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    hlw_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (scan_go),
        .here  (mem_rdata),
        .arr   (dir_add(heading_reg, 3'd3)),
        .rules (rules_reg),
        .res   (scan_res)
    );

    // result ports
    always_comb
    begin
        px_ext = EXT_W'(worm_x_reg);
        py_ext = EXT_W'(worm_y_reg);
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign pos_x      = px_ext[6:0];
    assign pos_y      = py_ext[6:0];
    assign direction  = heading_reg;
    assign node_edges = shown_reg;

endmodule

// ===== rtl/hlw_checker.sv =====
// port-level checks for the hex lattice worm step engine, bound to the top level
module hlw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic [2:0] direction,
    input logic [5:0] node_edges
);
    import hlw_pkg::*;

    logic [2:0] arrive_dir;

    // edge back toward where the worm came from
    assign arrive_dir = (direction >= 3'd3) ? direction - 3'd3 : direction + 3'd3;

    // a result is only shown with the engine free for the next command
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted command keeps the engine busy the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after transfer");

    // one result per command, never two in a row
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

    // after a move the new node has its arrival edge eaten
    a_arrival_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_MOVED) |-> node_edges[arrive_dir])
        else $error("arrival edge not marked after move");

endmodule

bind hex_lattice_worm_step hlw_checker u_hlw_checker (.*);
